// ===== hdl/csvfs_pkg.sv =====
// Shared types and constants for the CSV field splitter.
package csvfs_pkg;

    // Character codes the tokenizer reacts to.
    localparam logic [7:0] QUOTE_CH = 8'h22;
    localparam logic [7:0] COMMA_CH = 8'h2C;
    localparam logic [7:0] CR_CH    = 8'h0D;

    // Depth of the queue between the classifier and the field builder.
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // Operations the classifier hands to the field builder.
    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_ADD   = 2'd1,
        OP_FIELD = 2'd2,
        OP_LINE  = 2'd3
    } op_t;

    // One queued operation with its content byte.
    typedef struct packed {
        op_t        op;
        logic [7:0] ch;
    } q_entry_t;

endpackage

// ===== hdl/csvfs_front.sv =====
// Front end: accepts input transactions and classifies them against the quote state.
module csvfs_front
    import csvfs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_action,
    input  logic [7:0] s_ch,
    input  logic       q_full,
    output logic       q_push,
    output q_entry_t   q_wdata
);

    logic in_quotes_reg, in_quotes_next;
    logic pending_reg, pending_next;
    logic accept;
    logic outside;
    op_t  op;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    // Quote tracking and operation decode.
    always_comb begin
        in_quotes_next = in_quotes_reg;
        pending_next   = pending_reg;
        outside        = 1'b0;
        op             = OP_NONE;
        if (s_action) begin
            op             = OP_LINE;
            in_quotes_next = 1'b0;
            pending_next   = 1'b0;
        end else if (pending_reg) begin
            pending_next = 1'b0;
            if (s_ch == QUOTE_CH) begin
                // A doubled quote is a literal quote.
                op = OP_ADD;
            end else begin
                in_quotes_next = 1'b0;
                outside        = 1'b1;
            end
        end else if (in_quotes_reg) begin
            if (s_ch == QUOTE_CH) begin
                pending_next = 1'b1;
            end else begin
                op = OP_ADD;
            end
        end else begin
            outside = 1'b1;
        end

        // Handling of a byte seen outside quotes.
        if (outside) begin
            if (s_ch == QUOTE_CH) begin
                in_quotes_next = 1'b1;
            end else if (s_ch == COMMA_CH) begin
                op = OP_FIELD;
            end else if (s_ch != CR_CH) begin
                op = OP_ADD;
            end
        end
    end

    assign q_push     = accept && (op != OP_NONE);
    assign q_wdata.op = op;
    assign q_wdata.ch = s_ch;

    // Quote state advances on every accepted transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_quotes_reg <= 1'b0;
            pending_reg   <= 1'b0;
        end else if (accept) begin
            in_quotes_reg <= in_quotes_next;
            pending_reg   <= pending_next;
        end
    end

endmodule

// ===== hdl/csvfs_queue.sv =====
// Small register queue between the classifier and the field builder.
module csvfs_queue
    import csvfs_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  q_entry_t wdata,
    input  logic     pop,
    output q_entry_t rdata,
    output logic     full,
    output logic     empty
);

    q_entry_t            slots_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign full    = (count_reg == QCNT_W'(QDEPTH));
    assign empty   = (count_reg == '0);
    assign rdata   = slots_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Pointer and occupancy update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== hdl/csvfs_back.sv =====
// Back end: builds fields from queued operations and drives the result register.
module csvfs_back
    import csvfs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  q_entry_t   q_rdata,
    input  logic       q_empty,
    output logic       q_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_byte_valid,
    output logic       m_field_end,
    output logic       m_line_end
);

    logic       has_content_reg, has_content_next;
    logic       held_valid_reg, held_valid_next;
    logic [7:0] held_byte_reg, held_byte_next;
    logic       m_valid_reg;
    logic [7:0] out_byte_reg;
    logic       byte_valid_reg, field_end_reg, line_end_reg;
    logic       res_valid, res_bv, res_fe, res_le;
    logic [7:0] res_byte;
    logic       keep_held;

    // Take an operation when the result register is free or being drained.
    assign q_pop = !q_empty && (!m_valid_reg || m_ready);

    assign keep_held = held_valid_reg && (held_byte_reg != QUOTE_CH);

    // Field builder: one held-back byte strips a trailing quote.
    always_comb begin
        has_content_next = has_content_reg;
        held_valid_next  = held_valid_reg;
        held_byte_next   = held_byte_reg;
        res_valid        = 1'b0;
        res_byte         = 8'h00;
        res_bv           = 1'b0;
        res_fe           = 1'b0;
        res_le           = 1'b0;
        unique case (q_rdata.op) inside
            OP_ADD: begin
                has_content_next = 1'b1;
                // A leading quote of a field is dropped.
                if (has_content_reg || (q_rdata.ch != QUOTE_CH)) begin
                    if (held_valid_reg) begin
                        res_valid = 1'b1;
                        res_byte  = held_byte_reg;
                        res_bv    = 1'b1;
                    end
                    held_valid_next = 1'b1;
                    held_byte_next  = q_rdata.ch;
                end
            end
            OP_FIELD, OP_LINE: begin
                res_valid        = 1'b1;
                res_byte         = keep_held ? held_byte_reg : 8'h00;
                res_bv           = keep_held;
                res_fe           = 1'b1;
                res_le           = (q_rdata.op == OP_LINE);
                has_content_next = 1'b0;
                held_valid_next  = 1'b0;
                held_byte_next   = 8'h00;
            end
            OP_NONE: begin
                res_valid = 1'b0;
            end
        endcase
    end

    // Field state advances on every popped operation.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            has_content_reg <= 1'b0;
            held_valid_reg  <= 1'b0;
            held_byte_reg   <= 8'h00;
        end else if (q_pop) begin
            has_content_reg <= has_content_next;
            held_valid_reg  <= held_valid_next;
            held_byte_reg   <= held_byte_next;
        end
    end

    // Result register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (q_pop) begin
            m_valid_reg <= res_valid;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (q_pop && res_valid) begin
            out_byte_reg   <= res_byte;
            byte_valid_reg <= res_bv;
            field_end_reg  <= res_fe;
            line_end_reg   <= res_le;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_byte   = out_byte_reg;
    assign m_byte_valid = byte_valid_reg;
    assign m_field_end  = field_end_reg;
    assign m_line_end   = line_end_reg;

endmodule

// ===== hdl/csv_field_splitter_top.sv =====
// Top level of the CSV field splitter: classifier, queue and field builder.
// Path: an operation is first written into the queue, then the field builder puts its result
// in the result register. Throughput: one input transaction per cycle while m_ready is high,
// set by the two-entry queue and the single result register, which drain one operation per cycle.
// Reset: aresetn is synchronous and active low; it clears quote state, the
// held byte, the queue and the result valid flag.
module csv_field_splitter_top
    import csvfs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_action,
    input  logic [7:0] s_ch,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_byte_valid,
    output logic       m_field_end,
    output logic       m_line_end
);

    q_entry_t q_wdata, q_rdata;
    logic     q_push, q_pop, q_full, q_empty;

    // Classifier.
    csvfs_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_action(s_action),
        .s_ch    (s_ch),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_wdata (q_wdata)
    );

    // Decoupling queue.
    csvfs_queue u_queue (
        .aclk   (aclk),
        .aresetn(aresetn),
        .push   (q_push),
        .wdata  (q_wdata),
        .pop    (q_pop),
        .rdata  (q_rdata),
        .full   (q_full),
        .empty  (q_empty)
    );

    // Field builder.
    csvfs_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_rdata     (q_rdata),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_byte_valid(m_byte_valid),
        .m_field_end (m_field_end),
        .m_line_end  (m_line_end)
    );

endmodule

// ===== hdl/csvfs_checker.sv =====
// Port-level checker for the CSV field splitter, bound to the top level.
module csvfs_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_byte,
    input logic       m_byte_valid,
    input logic       m_field_end,
    input logic       m_line_end
);

    // A stalled result transaction holds its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte)
            && $stable(m_byte_valid) && $stable(m_field_end) && $stable(m_line_end))
        else $error("result changed while stalled");

    // A line end always closes a field.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_line_end |-> m_field_end)
        else $error("line end without field end");

    // A result without a byte carries a zero byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_byte_valid |-> (m_out_byte == 8'h00))
        else $error("nonzero byte in byteless result");

    // Every result carries either a byte or a field end.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_byte_valid || m_field_end)
        else $error("empty result");

    // Reset leaves no result pending.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind csv_field_splitter_top csvfs_checker u_csvfs_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_out_byte  (m_out_byte),
    .m_byte_valid(m_byte_valid),
    .m_field_end (m_field_end),
    .m_line_end  (m_line_end)
);
